// ===== rtl/rau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]                     opcode;
    logic signed [OPERAND_WIDTH_DEF-1:0] a_num;
    logic signed [OPERAND_WIDTH_DEF-1:0] a_den;
    logic signed [OPERAND_WIDTH_DEF-1:0] b_num;
    logic signed [OPERAND_WIDTH_DEF-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic                    status;
  } rau_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic comb;
    logic gcd_step;
    logic div_init;
    logic div_step;
  } rau_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;
    logic zero;
    logic gcd_done;
    logic div_done;
  } rau_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rau_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_datapath
// Products, sign fixup, binary gcd and restoring division by the gcd.
// ----------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; (
  input  wire logic     clk,
  input  wire rau_in_t  req,
  input  wire rau_cmd_t cmd,
  output rau_sts_t      sts,
  output rau_out_t      res
);

  localparam int OPERAND_WIDTH = OPERAND_WIDTH_DEF;
  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int MW = PW + 1;
  localparam int CW = $clog2(MW + 1);

  logic [1:0] op;
  logic signed [OPERAND_WIDTH-1:0] an, ad, bn, bd;
  logic signed [PW-1:0] p0, p1, pd;
  logic signed [MW-1:0] num_s;
  logic neg;
  logic [MW-1:0] x, y, mn, md, g;
  logic [CW-1:0] shf;
  logic [MW-1:0] qn, qd, rn, rd;
  logic [CW-1:0] cnt;
  logic [MW:0] rn_t, rd_t;
  logic signed [PW-1:0] m0a, m0b, m1a, m1b;

  assign rn_t = {rn, qn[MW-1]} - {1'b0, g};
  assign rd_t = {rd, qd[MW-1]} - {1'b0, g};

  always_comb begin
    m0a = PW'(an);
    m0b = (op == OP_MUL) ? PW'(bn) : PW'(bd);
    m1a = PW'(ad);
    m1b = (op == OP_DIV) ? PW'(bn) : PW'(bd);
  end

  always_comb begin
    case (op)
      OP_ADD:  num_s = MW'(p0) + MW'(p1);
      OP_SUB:  num_s = MW'(p0) - MW'(p1);
      default: num_s = MW'(p0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req.opcode;
      an <= OPERAND_WIDTH'(req.a_num);
      ad <= OPERAND_WIDTH'(req.a_den);
      bn <= OPERAND_WIDTH'(req.b_num);
      bd <= OPERAND_WIDTH'(req.b_den);
    end
    if (cmd.mul1) begin
      p0 <= m0a * m0b;
      pd <= m1a * m1b;
    end
    if (cmd.mul2) begin
      p1 <= PW'(ad) * PW'(bn);
    end
    if (cmd.comb) begin
      mn  <= num_s[MW-1] ? -num_s : num_s;
      md  <= pd[PW-1] ? MW'(-MW'(pd)) : MW'(pd);
      x   <= num_s[MW-1] ? -num_s : num_s;
      y   <= pd[PW-1] ? MW'(-MW'(pd)) : MW'(pd);
      neg <= num_s[MW-1] ^ pd[PW-1];
      shf <= '0;
    end
    if (cmd.gcd_step) begin
      if (x[0] == 1'b0 && y[0] == 1'b0) begin
        x <= x >> 1; y <= y >> 1; shf <= shf + 1'b1;
      end else if (x[0] == 1'b0) begin
        x <= x >> 1;
      end else if (y[0] == 1'b0) begin
        y <= y >> 1;
      end else if (x >= y) begin
        x <= (x - y) >> 1;
      end else begin
        y <= (y - x) >> 1;
      end
    end
    if (cmd.div_init) begin
      g   <= (x == '0 ? y : x) << shf;
      qn  <= mn; qd <= md; rn <= '0; rd <= '0;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      rn <= rn_t[MW] ? {rn[MW-2:0], qn[MW-1]} : rn_t[MW-1:0];
      qn <= {qn[MW-2:0], ~rn_t[MW]};
      rd <= rd_t[MW] ? {rd[MW-2:0], qd[MW-1]} : rd_t[MW-1:0];
      qd <= {qd[MW-2:0], ~rd_t[MW]};
      cnt <= cnt + 1'b1;
    end
  end

  assign sts.err = (ad == '0) || (bd == '0) || (op == OP_DIV && bn == '0);
  assign sts.zero = (mn == '0);
  assign sts.gcd_done = (x == '0) || (y == '0);
  assign sts.div_done = (cnt == CW'(MW));

  logic [MW-1:0] nmag;
  assign nmag = neg ? -qn : qn;
  assign res.res_num = NUM_W'($signed({nmag[MW-1], nmag}));
  assign res.res_den = DEN_W'(qd);
  assign res.status  = 1'b0;

endmodule
`default_nettype wire

// ===== rtl/rau_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for one request and the output register.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire rau_sts_t sts,
  input  wire rau_out_t dp_res,
  output rau_cmd_t      cmd,
  output rau_out_t      out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_MUL2, S_COMB, S_GCD, S_DIV, S_OUT
  } state_t;

  state_t   state;
  rau_out_t res_hold;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.mul1     = (state == S_CHK);
    cmd.mul2     = (state == S_MUL2);
    cmd.comb     = (state == S_COMB);
    cmd.gcd_step = (state == S_GCD) && !sts.gcd_done;
    cmd.div_init = (state == S_GCD) && sts.gcd_done;
    cmd.div_step = (state == S_DIV) && !sts.div_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT) begin
        if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_data  <= res_hold;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_valid) state <= S_CHK;
        S_CHK: begin
          if (sts.err) begin
            res_hold <= '{res_num: '0, res_den: DEN_W'(1), status: 1'b1};
            state    <= S_OUT;
          end else begin
            state <= S_MUL2;
          end
        end
        S_MUL2: state <= S_COMB;
        S_COMB: state <= S_GCD;
        S_GCD: begin
          if (sts.gcd_done) begin
            if (sts.zero) begin
              res_hold <= '{res_num: '0, res_den: DEN_W'(1), status: 1'b0};
              state    <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            res_hold <= dp_res;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add/sub/mul/div with reduction to lowest terms.
// ----------------------------------------------------------------------------
//  channel  | payload    | handshake
//  in       | rau_in_t   | in_valid / in_stall
//  out      | rau_out_t  | out_valid / out_stall
//
// one request at a time; the run time is set by the binary gcd loop
// and the bit-serial divider
// synchronous reset clears the sequencer and out_valid
// a result waits in the output register while out_stall is high, the next
// one waits in the sequencer until the output register frees
module rational_arithmetic_unit import rau_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire rau_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output rau_out_t     out_data
);

  rau_cmd_t cmd;
  rau_sts_t sts;
  rau_out_t dp_res;

  rau_datapath u_dp (
    .clk(clk), .req(in_data), .cmd(cmd), .sts(sts), .res(dp_res)
  );

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts),
    .dp_res(dp_res), .cmd(cmd), .out_data(out_data)
  );

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.comb, cmd.gcd_step,
              cmd.div_init, cmd.div_step})) else $error("overlapping commands");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.res_den != '0) else $error("zero denominator");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.gcd_step || cmd.div_step) |-> in_stall) else $error("accept while busy");

endmodule
`default_nettype wire
